// ===== design/brhs_pkg.sv =====
// brhs_pkg: shared types and constants for the brake release/hold sequencer
// holds the command and mode codes, register indexes, config and state records
// no dependencies
package brhs_pkg;

  // adc, field widths and offset arithmetic
  localparam int ADC_BITS   = 12;
  localparam int SAMPLE_W   = 12;
  localparam int LIMIT_W    = 12;
  localparam int DUTY_W     = 16;
  localparam int DELAY_W    = 16;
  localparam int OFFSET_W   = 18;
  localparam logic [OFFSET_W-1:0] ADC_HALF = OFFSET_W'(1 << (ADC_BITS - 1));

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOLD_LIMIT   = 3'd0,
    REG_UNLOCK_LIMIT = 3'd1,
    REG_UNLOCK_DUTY  = 3'd2,
    REG_HOLD_DUTY    = 3'd3,
    REG_UNLOCK_TIME  = 3'd4,
    REG_LOCK_TIME    = 3'd5
  } brhs_reg_t;

  // request commands
  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_ENABLE  = 2'd1,
    CMD_DISABLE = 2'd2,
    CMD_FAULT   = 2'd3
  } brhs_cmd_t;

  // brake states as shown on the result channel
  typedef enum logic [1:0] {
    MODE_IDLE      = 2'd0,
    MODE_UNLOCKING = 2'd1,
    MODE_HOLD      = 2'd2,
    MODE_LOCKING   = 2'd3
  } brhs_mode_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] hold_current_limit;
    logic [LIMIT_W-1:0] unlock_current_limit;
    logic [DUTY_W-1:0]  unlock_duty;
    logic [DUTY_W-1:0]  hold_duty;
    logic [DELAY_W-1:0] unlock_time;
    logic [DELAY_W-1:0] lock_time;
  } brhs_cfg_t;

  typedef struct packed {
    brhs_mode_t         mode;
    logic [DELAY_W-1:0] delay_count;
    logic               drive_on;
    logic [DUTY_W-1:0]  drive_duty;
    logic               pin_level;
  } brhs_state_t;

endpackage

// ===== design/brake_release_hold_sequencer_core.sv =====
// result: registered, valid in the cycle after its request is accepted
// throughput: one request per cycle unless in_stall is raised; the state register holds the result itself
// in_stall follows out_stall while a result waits, so nothing is dropped
// reset: synchronous active-low rst_n; state idle, drive off, counters and regs zero
// depends on brhs_pkg, brhs_cfg, brhs_step
module brake_release_hold_sequencer_core import brhs_pkg::*; #(
  parameter int FAULT_LIMIT = 100
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_command,
  input  logic [SAMPLE_W-1:0]   in_current_sample,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_pwm_on,
  output logic [DUTY_W-1:0]     out_pwm_duty,
  output logic                  out_hold_pin,
  output logic [1:0]            out_brake_state,
  output logic                  out_current_fault,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(FAULT_LIMIT + 1);

  brhs_cfg_t        cfg;
  brhs_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] low_cnt_r, low_cnt_nxt;
  logic             fault_r, fault_nxt;
  logic             out_valid_r;
  logic             in_accept;

  // configuration registers
  brhs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // per-request next state
  brhs_step #(
    .FAULT_LIMIT (FAULT_LIMIT),
    .CNT_W       (CNT_W)
  ) u_step (
    .command        (in_command),
    .current_sample (in_current_sample),
    .cfg            (cfg),
    .cur            (state_r),
    .low_cnt        (low_cnt_r),
    .nxt            (state_nxt),
    .low_cnt_nxt    (low_cnt_nxt),
    .flagged        (fault_nxt)
  );

  // handshake: take a request whenever the result slot is free or being taken
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      low_cnt_r   <= '0;
      fault_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        state_r   <= state_nxt;
        low_cnt_r <= low_cnt_nxt;
        fault_r   <= fault_nxt;
      end
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result fields are the registered levels
  assign out_valid         = out_valid_r;
  assign out_pwm_on        = state_r.drive_on;
  assign out_pwm_duty      = state_r.drive_duty;
  assign out_hold_pin      = state_r.pin_level;
  assign out_brake_state   = state_r.mode;
  assign out_current_fault = fault_r;

endmodule

// ===== design/brhs_cfg.sv =====
// brhs_cfg: configuration register file for the brake sequencer
// decodes register index writes into the brhs_cfg_t record; uses brhs_pkg
module brhs_cfg import brhs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output brhs_cfg_t             cfg
);

  brhs_cfg_t cfg_r;

  // writes always taken; cfg_ready is tied high
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // register decode, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HOLD_LIMIT:   cfg_r.hold_current_limit   <= cfg_data[LIMIT_W-1:0];
        REG_UNLOCK_LIMIT: cfg_r.unlock_current_limit <= cfg_data[LIMIT_W-1:0];
        REG_UNLOCK_DUTY:  cfg_r.unlock_duty          <= cfg_data[DUTY_W-1:0];
        REG_HOLD_DUTY:    cfg_r.hold_duty            <= cfg_data[DUTY_W-1:0];
        REG_UNLOCK_TIME:  cfg_r.unlock_time          <= cfg_data[DELAY_W-1:0];
        REG_LOCK_TIME:    cfg_r.lock_time            <= cfg_data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/brhs_step.sv =====
// brhs_step: next-state logic for one request of the brake sequencer
// current check, fault handling and state transitions; uses brhs_pkg
module brhs_step import brhs_pkg::*; #(
  parameter int FAULT_LIMIT = 100,
  parameter int CNT_W       = 7
) (
  input  logic [1:0]          command,
  input  logic [SAMPLE_W-1:0] current_sample,
  input  brhs_cfg_t           cfg,
  input  brhs_state_t         cur,
  input  logic [CNT_W-1:0]    low_cnt,
  output brhs_state_t         nxt,
  output logic [CNT_W-1:0]    low_cnt_nxt,
  output logic                flagged
);

  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(FAULT_LIMIT);

  logic signed [OFFSET_W-1:0] offset;
  logic signed [OFFSET_W-1:0] limit;
  logic [LIMIT_W-1:0]         limit_raw;
  logic                       in_check;
  logic                       below;
  logic                       fault_evt;
  logic                       delay_zero;
  logic [DELAY_W-1:0]         delay_dec;

  // offset current against the limit of the active state
  assign in_check  = (cur.mode == MODE_HOLD) || (cur.mode == MODE_UNLOCKING);
  assign limit_raw = (cur.mode == MODE_HOLD) ? cfg.hold_current_limit
                                             : cfg.unlock_current_limit;
  assign offset    = $signed({{(OFFSET_W-SAMPLE_W){1'b0}}, current_sample} - ADC_HALF);
  assign limit     = $signed({{(OFFSET_W-LIMIT_W){limit_raw[LIMIT_W-1]}}, limit_raw});
  assign below     = offset < limit;

  // delay test and countdown, wraps when already zero
  assign delay_zero = (cur.delay_count == '0);
  assign delay_dec  = cur.delay_count - DELAY_W'(1);

  always_comb begin
    nxt         = cur;
    low_cnt_nxt = low_cnt;
    flagged     = 1'b0;
    fault_evt   = (command == CMD_FAULT);

    // undercurrent counting on tick
    if (command == CMD_TICK) begin
      if (!in_check) begin
        low_cnt_nxt = '0;
      end else if (below) begin
        if (low_cnt < CNT_LIMIT) begin
          low_cnt_nxt = low_cnt + CNT_W'(1);
        end else begin
          flagged   = 1'b1;
          fault_evt = 1'b1;
        end
      end else begin
        low_cnt_nxt = '0;
      end
    end

    // transitions
    if (fault_evt) begin
      if (cur.mode != MODE_IDLE) begin
        nxt.drive_on   = 1'b0;
        nxt.drive_duty = '0;
        nxt.pin_level  = 1'b0;
        nxt.mode       = MODE_IDLE;
      end
    end else begin
      unique case (cur.mode)
        MODE_IDLE: begin
          if (command == CMD_ENABLE) begin
            nxt.drive_on    = 1'b1;
            nxt.drive_duty  = cfg.unlock_duty;
            nxt.delay_count = cfg.unlock_time;
            nxt.mode        = MODE_UNLOCKING;
          end
        end
        MODE_UNLOCKING: begin
          if (command == CMD_DISABLE) begin
            nxt.mode        = MODE_LOCKING;
            nxt.delay_count = cfg.lock_time;
            nxt.pin_level   = 1'b0;
            nxt.drive_on    = 1'b0;
            nxt.drive_duty  = '0;
          end else begin
            nxt.delay_count = delay_dec;
            if (delay_zero) begin
              nxt.drive_on   = 1'b1;
              nxt.drive_duty = cfg.hold_duty;
              nxt.pin_level  = 1'b1;
              nxt.mode       = MODE_HOLD;
            end
          end
        end
        MODE_HOLD: begin
          if (command == CMD_DISABLE) begin
            nxt.mode        = MODE_LOCKING;
            nxt.delay_count = cfg.lock_time;
            nxt.pin_level   = 1'b0;
            nxt.drive_on    = 1'b0;
            nxt.drive_duty  = '0;
          end
        end
        MODE_LOCKING: begin
          // disable and tick both count the lock delay down
          if (command == CMD_ENABLE) begin
            nxt.drive_on    = 1'b1;
            nxt.drive_duty  = cfg.unlock_duty;
            nxt.delay_count = cfg.unlock_time;
            nxt.mode        = MODE_UNLOCKING;
          end else begin
            nxt.delay_count = delay_dec;
            if (delay_zero) begin
              nxt.drive_on   = 1'b0;
              nxt.drive_duty = '0;
              nxt.pin_level  = 1'b0;
              nxt.mode       = MODE_IDLE;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/brhs_checker.sv =====
// brhs_checker: port-level assertions for the brake sequencer core
// bound to brake_release_hold_sequencer_core; uses brhs_pkg
module brhs_checker import brhs_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_pwm_on,
  input logic [DUTY_W-1:0] out_pwm_duty,
  input logic              out_hold_pin,
  input logic [1:0]        out_brake_state,
  input logic              out_current_fault
);

  // duty is zero whenever the drive is off
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pwm_on |-> out_pwm_duty == '0)
    else $error("duty nonzero with drive off");

  // hold pin only in hold, with drive on
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hold_pin |-> out_brake_state == MODE_HOLD && out_pwm_on)
    else $error("hold pin outside hold");

  // idle and locking never drive the coil
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_brake_state == MODE_IDLE || out_brake_state == MODE_LOCKING)
      |-> !out_pwm_on && !out_hold_pin)
    else $error("drive active while idle or locking");

  // an undercurrent fault always lands in idle
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_current_fault |-> out_brake_state == MODE_IDLE)
    else $error("current fault not in idle");

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pwm_duty)
      && $stable(out_brake_state) && $stable(out_current_fault))
    else $error("stalled result changed");

endmodule

bind brake_release_hold_sequencer_core brhs_checker u_brhs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_pwm_on        (out_pwm_on),
  .out_pwm_duty      (out_pwm_duty),
  .out_hold_pin      (out_hold_pin),
  .out_brake_state   (out_brake_state),
  .out_current_fault (out_current_fault)
);
